/* rtl/core/prm_pkg.sv */
// prm_pkg: shared types and constants of the pulse interval rate meter
// used by the channel interfaces, the controller, the datapath and the top level
package prm_pkg;

   // input sample and result field widths
   localparam int unsigned SAMPLE_W    = 13;
   localparam int unsigned LEVEL_W     = 12;
   localparam int unsigned RATE_W      = 8;
   localparam int unsigned STATUS_W    = 2;

   // configuration register widths
   localparam int unsigned CSR_INDEX_W = 3;
   localparam int unsigned CSR_DATA_W  = 20;
   localparam int unsigned INTERVAL_W  = 16;
   localparam int unsigned NUMER_W     = 20;

   // time base and interval ring
   localparam int unsigned TICK_W      = 32;
   localparam int unsigned RING_DEPTH  = 10;
   localparam int unsigned SLOT_W      = 4;
   localparam int unsigned TRIM_LO     = 3;
   localparam int unsigned TRIM_HI     = 7;
   localparam int unsigned SUM_W       = 19;
   localparam int unsigned COUNT_W     = 5;

   // register reset values
   localparam logic [LEVEL_W-1:0]    HIGH_THRESHOLD_RST = 12'd1000;
   localparam logic [LEVEL_W-1:0]    LOW_THRESHOLD_RST  = 12'd20;
   localparam logic [INTERVAL_W-1:0] MIN_INTERVAL_RST   = 16'd300;
   localparam logic [INTERVAL_W-1:0] MAX_INTERVAL_RST   = 16'd2000;
   localparam logic [INTERVAL_W-1:0] SPREAD_LIMIT_RST   = 16'd120;
   localparam logic [NUMER_W-1:0]    RATE_NUMERATOR_RST = 20'd300000;

   localparam logic [RATE_W-1:0]     RATE_MAX           = 8'd255;

   // register indexes
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_HIGH_THRESHOLD = 3'd0,
      CSR_LOW_THRESHOLD  = 3'd1,
      CSR_MIN_INTERVAL   = 3'd2,
      CSR_MAX_INTERVAL   = 3'd3,
      CSR_SPREAD_LIMIT   = 3'd4,
      CSR_RATE_NUMERATOR = 3'd5
   } prm_csr_type;

   // result status codes
   typedef enum logic [STATUS_W-1:0] {
      CODE_NO_PULSE = 2'd0,
      CODE_FILLING  = 2'd1,
      CODE_SPREAD   = 2'd2,
      CODE_VALID    = 2'd3
   } prm_code_type;

   // controller states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_EVAL,
      ST_COPY,
      ST_SORT,
      ST_CHECK,
      ST_SUM,
      ST_DIV,
      ST_QUOT,
      ST_FINISH
   } prm_state_type;

   // controller to datapath commands
   typedef struct packed {
      logic load;
      logic eval;
      logic copy;
      logic sort;
      logic check;
      logic sum;
      logic div;
      logic quot;
      logic emit;
   } prm_cmd_type;

   // datapath to controller status
   typedef struct packed {
      logic pulse;
      logic full_next;
      logic spread_bad;
      logic sort_done;
      logic sum_done;
      logic div_done;
   } prm_stat_type;

endpackage

/* rtl/core/prm_req_if.sv */
// prm_req_if: request channel carrying one sensor sample
// depends on prm_pkg for the field width
interface prm_req_if import prm_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic signed [SAMPLE_W-1:0] sample;

   modport source (output valid, output sample, input ready);
   modport sink   (input valid, input sample, output ready);
endinterface

/* rtl/core/prm_rsp_if.sv */
// prm_rsp_if: result channel carrying rate and status
// depends on prm_pkg for the field widths
interface prm_rsp_if import prm_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [RATE_W-1:0]   rate;
   logic [STATUS_W-1:0] status;

   modport source (output valid, output rate, output status, input ready);
   modport sink   (input valid, input rate, input status, output ready);
endinterface

/* rtl/core/prm_csr_if.sv */
// prm_csr_if: configuration write channel, register index and write data
// depends on prm_pkg for the field widths
interface prm_csr_if import prm_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [CSR_INDEX_W-1:0] index;
   logic [CSR_DATA_W-1:0]  data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/prm_ctrl.sv */
// prm_ctrl: sequencing state machine of the rate meter
// depends on prm_pkg for the state, command and status types
module prm_ctrl import prm_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   input  prm_stat_type stat,
   output prm_cmd_type  cmd
);

   prm_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_EVAL;
         end
         ST_EVAL: begin
            if (!stat.pulse || !stat.full_next) state_in = ST_FINISH;
            else state_in = ST_COPY;
         end
         ST_COPY:  state_in = ST_SORT;
         ST_SORT: begin
            if (stat.sort_done) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (stat.spread_bad) state_in = ST_FINISH;
            else state_in = ST_SUM;
         end
         ST_SUM: begin
            if (stat.sum_done) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (stat.div_done) state_in = ST_QUOT;
         end
         ST_QUOT:  state_in = ST_FINISH;
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) state_in = ST_IDLE;
         end
         default:  state_in = ST_IDLE;
      endcase
   end

   // commands and handshake outputs
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_EVAL:   cmd.eval  = 1'b1;
         ST_COPY:   cmd.copy  = 1'b1;
         ST_SORT:   cmd.sort  = 1'b1;
         ST_CHECK:  cmd.check = 1'b1;
         ST_SUM:    cmd.sum   = 1'b1;
         ST_DIV:    cmd.div   = 1'b1;
         ST_QUOT:   cmd.quot  = 1'b1;
         ST_FINISH: cmd.emit  = !rsp_valid_ff || rsp_ready;
         default: begin
            cmd       = '0;
            req_ready = 1'b0;
         end
      endcase
   end

   // output register valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) rsp_valid_in = 1'b1;
      else if (rsp_ready) rsp_valid_in = 1'b0;
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* rtl/core/prm_dp.sv */
// prm_dp: datapath of the rate meter, registers, ring, sorter, summer, divider
// depends on prm_pkg for widths, codes and the command and status types
module prm_dp import prm_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  prm_cmd_type                cmd,
   output prm_stat_type               stat,
   input  logic signed [SAMPLE_W-1:0] req_sample,
   input  logic                       csr_write,
   input  logic [CSR_INDEX_W-1:0]     csr_index,
   input  logic [CSR_DATA_W-1:0]      csr_data,
   output logic [RATE_W-1:0]          rsp_rate,
   output logic [STATUS_W-1:0]        rsp_status
);

   // configuration registers
   logic [LEVEL_W-1:0]    high_threshold_ff;
   logic [LEVEL_W-1:0]    low_threshold_ff;
   logic [INTERVAL_W-1:0] min_interval_ff;
   logic [INTERVAL_W-1:0] max_interval_ff;
   logic [INTERVAL_W-1:0] spread_limit_ff;
   logic [NUMER_W-1:0]    rate_numerator_ff;

   // tracking state
   logic [LEVEL_W-1:0]    sample_ff;
   logic [LEVEL_W-1:0]    previous_ff;
   logic [TICK_W-1:0]     tick_ff;
   logic [TICK_W-1:0]     last_pulse_ff;
   logic [INTERVAL_W-1:0] ring_ff [RING_DEPTH];
   logic [SLOT_W-1:0]     slot_ff;
   logic                  full_ff;

   // work registers
   logic [INTERVAL_W-1:0] sorted_ff [RING_DEPTH];
   logic [INTERVAL_W-1:0] sorted_in [RING_DEPTH];
   logic [COUNT_W-1:0]    count_ff;
   logic [SUM_W-1:0]      sum_ff;
   logic [NUMER_W-1:0]    quo_ff;
   logic [SUM_W-1:0]      rem_ff;
   logic [RATE_W-1:0]     res_rate_ff;
   prm_code_type          res_code_ff;
   logic [RATE_W-1:0]     out_rate_ff;
   logic [STATUS_W-1:0]   out_status_ff;

   // sample judgment
   logic [LEVEL_W-1:0]    clamped;
   logic [TICK_W-1:0]     tick_in;
   logic [TICK_W-1:0]     interval;
   logic                  pulse;
   logic                  store;
   logic                  slot_last;
   logic [INTERVAL_W-1:0] spread;
   logic [SUM_W:0]        trial;
   logic [SUM_W:0]        shifted;

   assign clamped   = req_sample[SAMPLE_W-1] ? '0 : req_sample[LEVEL_W-1:0];
   assign tick_in   = tick_ff + 32'd1;
   assign interval  = tick_in - last_pulse_ff;
   assign pulse     = (sample_ff > high_threshold_ff) && (previous_ff < low_threshold_ff);
   assign store     = pulse && (interval > {16'd0, min_interval_ff})
                      && (interval < {16'd0, max_interval_ff});
   assign slot_last = (slot_ff == SLOT_W'(RING_DEPTH - 1));
   assign spread    = sorted_ff[TRIM_HI] - sorted_ff[TRIM_LO];

   // one restoring division step
   assign shifted = {rem_ff, quo_ff[NUMER_W-1]};
   assign trial   = shifted - {1'b0, sum_ff};

   // status to the controller
   assign stat.pulse      = pulse;
   assign stat.full_next  = full_ff || (store && slot_last);
   assign stat.spread_bad = spread > spread_limit_ff;
   assign stat.sort_done  = (count_ff == COUNT_W'(RING_DEPTH - 1));
   assign stat.sum_done   = (count_ff == COUNT_W'(TRIM_HI));
   assign stat.div_done   = (count_ff == COUNT_W'(NUMER_W - 1));

   // one odd-even transposition pass, phase chosen by the pass count
   always_comb begin
      for (int i = 0; i < RING_DEPTH; i++) sorted_in[i] = sorted_ff[i];
      for (int i = 0; i < RING_DEPTH - 1; i++) begin
         if ((i % 2 == int'(count_ff[0])) && (sorted_ff[i] > sorted_ff[i+1])) begin
            sorted_in[i]   = sorted_ff[i+1];
            sorted_in[i+1] = sorted_ff[i];
         end
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         high_threshold_ff <= HIGH_THRESHOLD_RST;
         low_threshold_ff  <= LOW_THRESHOLD_RST;
         min_interval_ff   <= MIN_INTERVAL_RST;
         max_interval_ff   <= MAX_INTERVAL_RST;
         spread_limit_ff   <= SPREAD_LIMIT_RST;
         rate_numerator_ff <= RATE_NUMERATOR_RST;
      end else if (csr_write) begin
         case (csr_index)
            CSR_HIGH_THRESHOLD: high_threshold_ff <= csr_data[LEVEL_W-1:0];
            CSR_LOW_THRESHOLD:  low_threshold_ff  <= csr_data[LEVEL_W-1:0];
            CSR_MIN_INTERVAL:   min_interval_ff   <= csr_data[INTERVAL_W-1:0];
            CSR_MAX_INTERVAL:   max_interval_ff   <= csr_data[INTERVAL_W-1:0];
            CSR_SPREAD_LIMIT:   spread_limit_ff   <= csr_data[INTERVAL_W-1:0];
            CSR_RATE_NUMERATOR: rate_numerator_ff <= csr_data[NUMER_W-1:0];
            default: ;
         endcase
      end
   end

   // tick, pulse history and interval ring
   always_ff @(posedge clock) begin
      if (reset) begin
         previous_ff   <= '0;
         tick_ff       <= '0;
         last_pulse_ff <= '0;
         slot_ff       <= '0;
         full_ff       <= 1'b0;
         for (int i = 0; i < RING_DEPTH; i++) ring_ff[i] <= '0;
      end else if (cmd.eval) begin
         tick_ff     <= tick_in;
         previous_ff <= sample_ff;
         if (pulse) last_pulse_ff <= tick_in;
         if (store) begin
            ring_ff[slot_ff] <= interval[INTERVAL_W-1:0];
            if (slot_last) begin
               full_ff <= 1'b1;
               slot_ff <= '0;
            end else begin
               slot_ff <= slot_ff + 4'd1;
            end
         end
      end
   end

   // sample capture, ring copy, sort passes, spread check, sum, divide and result
   always_ff @(posedge clock) begin
      if (cmd.load) sample_ff <= clamped;

      if (cmd.eval) begin
         res_code_ff <= pulse ? CODE_FILLING : CODE_NO_PULSE;
         res_rate_ff <= '0;
      end

      if (cmd.copy) begin
         for (int i = 0; i < RING_DEPTH; i++) sorted_ff[i] <= ring_ff[i];
         count_ff <= '0;
      end

      if (cmd.sort) begin
         for (int i = 0; i < RING_DEPTH; i++) sorted_ff[i] <= sorted_in[i];
         count_ff <= count_ff + 5'd1;
      end

      if (cmd.check) begin
         if (stat.spread_bad) res_code_ff <= CODE_SPREAD;
         sum_ff   <= '0;
         quo_ff   <= rate_numerator_ff;
         rem_ff   <= '0;
         count_ff <= COUNT_W'(TRIM_LO);
      end

      if (cmd.sum) begin
         sum_ff <= sum_ff + {3'd0, sorted_ff[count_ff[SLOT_W-1:0]]};
         if (stat.sum_done) count_ff <= '0;
         else count_ff <= count_ff + 5'd1;
      end

      if (cmd.div) begin
         if (!trial[SUM_W]) begin
            rem_ff <= trial[SUM_W-1:0];
            quo_ff <= {quo_ff[NUMER_W-2:0], 1'b1};
         end else begin
            rem_ff <= shifted[SUM_W-1:0];
            quo_ff <= {quo_ff[NUMER_W-2:0], 1'b0};
         end
         count_ff <= count_ff + 5'd1;
      end

      // saturate the quotient to the rate range
      if (cmd.quot) begin
         res_code_ff <= CODE_VALID;
         if (quo_ff > {12'd0, RATE_MAX}) res_rate_ff <= RATE_MAX;
         else res_rate_ff <= quo_ff[RATE_W-1:0];
      end

      if (cmd.emit) begin
         out_rate_ff   <= res_rate_ff;
         out_status_ff <= res_code_ff;
      end
   end

   assign rsp_rate   = out_rate_ff;
   assign rsp_status = out_status_ff;

endmodule

/* rtl/core/pulse_interval_rate_meter.sv */
// Pulse interval rate meter. Each request carries one sensor sample (one tick); every
// request yields exactly one response with rate and status. A sample that marks no
// pulse, or a pulse while the ring of ten intervals is still filling, goes from the
// evaluate state straight to the finish state, and the next request is taken after
// that. Once the ring is full a pulse is answered after ten odd-even transposition
// passes over a copy of the ring, a spread check, the sum of the five trimmed entries
// and twenty steps of a one-bit restoring divider that set the figure; only then is the
// next request taken. A pulse rejected for spread skips the sum and the divide. The
// finish state of a request waits while the previous response is still held in the
// output register.
// A new request is taken while a finished response still waits in the output register.
// Configuration registers are written through the csr channel, which is always ready,
// and must only be written while the block is idle.
module pulse_interval_rate_meter import prm_pkg::*; (
   input logic clock,
   input logic reset,
   prm_req_if.sink   req_chan,
   prm_rsp_if.source rsp_chan,
   prm_csr_if.sink   csr_chan
);

   prm_cmd_type  cmd;
   prm_stat_type stat;
   logic         ctrl_req_ready;
   logic         ctrl_rsp_valid;

   // configuration writes are always taken
   assign csr_chan.ready = 1'b1;
   assign req_chan.ready = ctrl_req_ready;
   assign rsp_chan.valid = ctrl_rsp_valid;

   // sequencer
   prm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (ctrl_req_ready),
      .rsp_valid (ctrl_rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath
   prm_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_sample (req_chan.sample),
      .csr_write  (csr_chan.valid),
      .csr_index  (csr_chan.index),
      .csr_data   (csr_chan.data),
      .rsp_rate   (rsp_chan.rate),
      .rsp_status (rsp_chan.status)
   );

endmodule

/* dv/pulse_interval_rate_meter_tb.sv */
`timescale 1ns / 100ps
// pulse_interval_rate_meter_tb: self-checking bench for the pulse interval rate meter
// drives samples and CSR writes, checks rate results by local predictor or directed rows
// depends on prm_pkg and the prm_req_if, prm_rsp_if and prm_csr_if interfaces
module pulse_interval_rate_meter_tb;
   import prm_pkg::*;

   localparam int HALF_PERIOD = 5;
   localparam int RESET_CYCLES = 5;
   localparam int DRAIN_CYCLES = 60;
   localparam int RUN_LIMIT_NS = 5_000_000;
   localparam int MAX_PRINTED = 40;

   // register indexes that decode to nothing
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_A = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_B = 3'd7;

   typedef struct {
      logic [RATE_W-1:0] rate;
      prm_code_type      status;
   } rate_result_type;

   typedef enum {ROW_SAMPLE, ROW_WRITE} row_kind_type;

   typedef struct {
      row_kind_type               kind;
      logic signed [SAMPLE_W-1:0] sample;
      bit                         typed;
      rate_result_type            fixed;
      prm_csr_type                reg_index;
      logic [CSR_DATA_W-1:0]      value;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset;

   prm_req_if req_if ();
   prm_rsp_if rsp_if ();
   prm_csr_if csr_if ();

   pulse_interval_rate_meter u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   // register copies
   logic [LEVEL_W-1:0]    cfg_high   = HIGH_THRESHOLD_RST;
   logic [LEVEL_W-1:0]    cfg_low    = LOW_THRESHOLD_RST;
   logic [INTERVAL_W-1:0] cfg_min    = MIN_INTERVAL_RST;
   logic [INTERVAL_W-1:0] cfg_max    = MAX_INTERVAL_RST;
   logic [INTERVAL_W-1:0] cfg_spread = SPREAD_LIMIT_RST;
   logic [NUMER_W-1:0]    cfg_numer  = RATE_NUMERATOR_RST;

   // predicted meter state
   logic [LEVEL_W-1:0]    prev_level = '0;
   logic [TICK_W-1:0]     tick_now = '0;
   logic [TICK_W-1:0]     last_pulse_tick = '0;
   logic [INTERVAL_W-1:0] intervals [RING_DEPTH] = '{default: '0};
   int                    next_slot = 0;
   bit                    ring_filled = 1'b0;

   rate_result_type rates_due [$];
   stim_row_type    plan [$];
   int              mismatch_count = 0;
   bit              steady = 1'b0;
   int              jitter_span = 4;

   // clock
   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // run limit
   initial begin
      #RUN_LIMIT_NS;
      $display("Test completed with failures");
      $finish;
   end

   task automatic report_mismatch(input string msg);
      if (mismatch_count < MAX_PRINTED) $display("%0t ns: %s", $time, msg);
      mismatch_count++;
   endtask

   function automatic void take_register(input logic [CSR_INDEX_W-1:0] idx,
                                         input logic [CSR_DATA_W-1:0] value);
      case (idx)
         CSR_HIGH_THRESHOLD: cfg_high   = value[LEVEL_W-1:0];
         CSR_LOW_THRESHOLD:  cfg_low    = value[LEVEL_W-1:0];
         CSR_MIN_INTERVAL:   cfg_min    = value[INTERVAL_W-1:0];
         CSR_MAX_INTERVAL:   cfg_max    = value[INTERVAL_W-1:0];
         CSR_SPREAD_LIMIT:   cfg_spread = value[INTERVAL_W-1:0];
         CSR_RATE_NUMERATOR: cfg_numer  = value[NUMER_W-1:0];
         default: ;
      endcase
   endfunction

   // advance the meter by one tick and work out the rate result it gives
   function automatic rate_result_type rate_for_sample(input logic [SAMPLE_W-1:0] raw);
      logic [LEVEL_W-1:0]    level;
      logic [TICK_W-1:0]     gap;
      logic [INTERVAL_W-1:0] ord [RING_DEPTH];
      logic [INTERVAL_W-1:0] v;
      logic [SUM_W-1:0]      trim_sum;
      logic [NUMER_W-1:0]    quot;
      bit                    pulse;
      rate_result_type       r;
      int                    i, j;
      level = raw[SAMPLE_W-1] ? '0 : raw[LEVEL_W-1:0];
      tick_now = tick_now + 32'd1;
      pulse = (level > cfg_high) && (prev_level < cfg_low);
      prev_level = level;
      r.rate = '0;
      r.status = CODE_NO_PULSE;
      if (!pulse) return r;

      // interval since the last pulse, kept only inside the limits
      gap = tick_now - last_pulse_tick;
      last_pulse_tick = tick_now;
      if (gap > cfg_min && gap < cfg_max) begin
         intervals[next_slot] = gap[INTERVAL_W-1:0];
         if (next_slot == RING_DEPTH - 1) ring_filled = 1'b1;
         next_slot = (next_slot + 1) % RING_DEPTH;
      end
      if (!ring_filled) begin
         r.status = CODE_FILLING;
         return r;
      end

      // sorted copy, then spread check on the trimmed middle
      ord = intervals;
      for (i = 0; i < RING_DEPTH - 1; i++) begin
         for (j = 0; j < RING_DEPTH - 1 - i; j++) begin
            if (ord[j] > ord[j+1]) begin
               v = ord[j];
               ord[j] = ord[j+1];
               ord[j+1] = v;
            end
         end
      end
      if (ord[TRIM_HI] - ord[TRIM_LO] > cfg_spread) begin
         r.status = CODE_SPREAD;
         return r;
      end

      trim_sum = '0;
      for (i = TRIM_LO; i <= TRIM_HI; i++) trim_sum = trim_sum + ord[i];
      if (trim_sum == 0) quot = NUMER_W'(RATE_MAX);
      else quot = cfg_numer / trim_sum;
      r.rate = (quot > RATE_MAX) ? RATE_MAX : quot[RATE_W-1:0];
      r.status = CODE_VALID;
      return r;
   endfunction

   // one request, with random idle cycles ahead of it outside the steady phase
   task automatic push_sample(input logic [SAMPLE_W-1:0] s);
      while (!steady && $urandom_range(0, 99) < 15) begin
         req_if.valid <= 1'b0;
         @(posedge clock);
      end
      req_if.valid <= 1'b1;
      req_if.sample <= s;
      do @(posedge clock); while (!req_if.ready);
      rates_due.push_back(rate_for_sample(s));
   endtask

   // hold off requests until every pending rate result is back
   task automatic drain_requests();
      req_if.valid <= 1'b0;
      while (rates_due.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data <= value;
      do @(posedge clock); while (!csr_if.ready);
      take_register(idx, value);
   endtask

   task automatic close_writes();
      csr_if.valid <= 1'b0;
   endtask

   // write all six registers, with junk in the unused upper bits of the five narrower ones
   task automatic configure(input logic [LEVEL_W-1:0] h, input logic [LEVEL_W-1:0] l,
                            input logic [INTERVAL_W-1:0] mn, input logic [INTERVAL_W-1:0] mx,
                            input logic [INTERVAL_W-1:0] sp, input logic [NUMER_W-1:0] nu);
      logic [CSR_DATA_W-1:0] junk;
      junk = CSR_DATA_W'($urandom);
      write_register(CSR_HIGH_THRESHOLD, {junk[CSR_DATA_W-1:LEVEL_W], h});
      write_register(CSR_LOW_THRESHOLD, {junk[CSR_DATA_W-1:LEVEL_W], l});
      junk = CSR_DATA_W'($urandom);
      write_register(CSR_MIN_INTERVAL, {junk[CSR_DATA_W-1:INTERVAL_W], mn});
      write_register(CSR_MAX_INTERVAL, {junk[CSR_DATA_W-1:INTERVAL_W], mx});
      write_register(CSR_SPREAD_LIMIT, {junk[CSR_DATA_W-1:INTERVAL_W], sp});
      write_register(CSR_RATE_NUMERATOR, nu);
   endtask

   // sample that counts as quiet before a pulse, or any sample when the low threshold is zero
   function automatic logic [SAMPLE_W-1:0] low_sample();
      if (cfg_low == 0) return SAMPLE_W'($urandom_range(0, 8191));
      if ($urandom_range(0, 99) < 25) return SAMPLE_W'($urandom_range(4096, 8191));
      return SAMPLE_W'($urandom_range(0, cfg_low - 1));
   endfunction

   function automatic logic [SAMPLE_W-1:0] high_sample();
      if (cfg_high == 12'd4095) return SAMPLE_W'($urandom_range(0, 4095));
      return SAMPLE_W'($urandom_range(cfg_high + 1, 4095));
   endfunction

   // ticks between pulses, mostly inside the storing window
   function automatic int pick_gap();
      int lo, hi;
      lo = int'(cfg_min) + 1;
      if (lo < 2) lo = 2;
      hi = int'(cfg_max) - 1;
      if (hi > lo + jitter_span) hi = lo + jitter_span;
      if (lo > hi || lo > 80 || $urandom_range(0, 99) < 15) return $urandom_range(2, 40);
      return $urandom_range(lo, hi);
   endfunction

   // pulse trains with random content, some noise and broken trains
   task automatic run_beats(input int count);
      int sent, gap, i;
      logic [SAMPLE_W-1:0] s;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 15) begin
            push_sample(SAMPLE_W'($urandom_range(0, 8191)));
            sent++;
         end else begin
            gap = pick_gap();
            for (i = 0; i < gap - 1; i++) begin
               if (i == gap - 2 && $urandom_range(0, 99) >= 10) s = low_sample();
               else s = SAMPLE_W'($urandom_range(0, cfg_high));
               push_sample(s);
            end
            push_sample(high_sample());
            sent += gap;
         end
      end
   endtask

   function automatic void add_sample(input logic signed [SAMPLE_W-1:0] s, input bit typed,
                                      input prm_code_type st, input logic [RATE_W-1:0] r);
      stim_row_type row;
      row.kind = ROW_SAMPLE;
      row.sample = s;
      row.typed = typed;
      row.fixed.rate = r;
      row.fixed.status = st;
      plan.push_back(row);
   endfunction

   function automatic void add_write(input prm_csr_type idx, input logic [CSR_DATA_W-1:0] d);
      stim_row_type row;
      row.kind = ROW_WRITE;
      row.reg_index = idx;
      row.value = d;
      row.typed = 1'b0;
      plan.push_back(row);
   endfunction

   // rate result checker and random backpressure
   always @(posedge clock) begin
      rate_result_type due;
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else begin
         rsp_if.ready <= steady || ($urandom_range(0, 99) >= 15);
         if (rsp_if.valid && rsp_if.ready) begin
            if (rates_due.size() == 0) begin
               report_mismatch($sformatf("rate result with none pending: rate %0d status %0d",
                                         rsp_if.rate, rsp_if.status));
            end else begin
               due = rates_due.pop_front();
               if (rsp_if.rate !== due.rate)
                  report_mismatch($sformatf("rate %0d, expected %0d", rsp_if.rate, due.rate));
               if (rsp_if.status !== due.status)
                  report_mismatch($sformatf("status %0d, expected %0d",
                                            rsp_if.status, due.status));
            end
         end
      end
   end

   initial begin
      int phase_items [8];
      int k, phase;
      bit writing;
      stim_row_type row;
      logic [LEVEL_W-1:0] h, l;
      logic [INTERVAL_W-1:0] mn, mx;

      phase_items = '{200, 250, 180, 150, 160, 60, 200, 200};
      reset = 1'b1;
      req_if.valid = 1'b0;
      req_if.sample = '0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;

      // directed table: threshold edges, clamping, rejected intervals,
      // then a ring of equal intervals that ends in a saturated rate
      add_sample(13'sd0, 1'b1, CODE_NO_PULSE, 8'd0);
      add_sample(13'sd4095, 1'b1, CODE_FILLING, 8'd0);
      add_sample(-13'sd1, 1'b1, CODE_NO_PULSE, 8'd0);
      add_sample(13'sd1000, 1'b1, CODE_NO_PULSE, 8'd0);
      add_sample(13'sd19, 1'b1, CODE_NO_PULSE, 8'd0);
      add_sample(13'sd1001, 1'b1, CODE_FILLING, 8'd0);
      add_write(CSR_MIN_INTERVAL, 20'd1);
      add_write(CSR_MAX_INTERVAL, 20'd3);
      add_write(CSR_RATE_NUMERATOR, 20'hFFFFF);
      add_write(CSR_SPREAD_LIMIT, 20'd0);
      for (k = 0; k < RING_DEPTH; k++) begin
         add_sample(-13'sd2048, 1'b1, CODE_NO_PULSE, 8'd0);
         add_sample(k[0] ? 13'sd1001 : 13'sd4095, 1'b1,
                    (k == RING_DEPTH - 1) ? CODE_VALID : CODE_FILLING,
                    (k == RING_DEPTH - 1) ? RATE_MAX : 8'd0);
      end

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // walk the table
      writing = 1'b0;
      for (k = 0; k < plan.size(); k++) begin
         row = plan[k];
         if (row.kind == ROW_WRITE) begin
            if (!writing) drain_requests();
            write_register(row.reg_index, row.value);
            writing = 1'b1;
         end else begin
            if (writing) close_writes();
            writing = 1'b0;
            push_sample(row.sample);
            if (row.typed) rates_due[rates_due.size()-1] = row.fixed;
         end
      end

      // random phases, each under its own register setting
      for (phase = 0; phase < 8; phase++) begin
         drain_requests();
         steady = (phase == 1);
         jitter_span = $urandom_range(0, 10);
         h = LEVEL_W'($urandom_range(200, 3500));
         l = LEVEL_W'($urandom_range(1, h));
         mn = INTERVAL_W'($urandom_range(1, 6));
         mx = mn + INTERVAL_W'($urandom_range(4, 24));
         case (phase)
            2: configure(12'd0, 12'd4095, 16'd1, 16'hFFFF, 16'hFFFF, 20'hFFFFF);
            3: begin
               configure(h, l, mn, mx, 16'hFFFF, 20'd0);
               write_register(CSR_SPARE_A, CSR_DATA_W'($urandom));
               write_register(CSR_SPARE_B, CSR_DATA_W'($urandom));
            end
            4: begin
               // window too narrow to store anything
               mn = INTERVAL_W'($urandom_range(2, 40));
               case ($urandom_range(0, 2))
                  0: mx = mn + 16'd1;
                  1: mx = mn;
                  default: mx = INTERVAL_W'($urandom_range(1, mn - 1));
               endcase
               configure(h, l, mn, mx, INTERVAL_W'($urandom_range(0, 12)),
                         NUMER_W'($urandom_range(1, 20000)));
            end
            5: configure(12'd4095, 12'd0, 16'hFFFF, 16'd0, 16'd0, 20'd1);
            6: configure(h, l, 16'd1, 16'd10, 16'd0, 20'hFFFFF);
            default: configure(h, l, mn, mx, INTERVAL_W'($urandom_range(0, 12)),
                               $urandom_range(0, 1) ? NUMER_W'($urandom_range(1, 20000))
                                                    : NUMER_W'($urandom_range(1, 20'hFFFFF)));
         endcase
         close_writes();
         run_beats(phase_items[phase]);
      end

      // wind down
      drain_requests();
      steady = 1'b0;
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

/* sim.f */
rtl/core/prm_pkg.sv
rtl/core/prm_req_if.sv
rtl/core/prm_rsp_if.sv
rtl/core/prm_csr_if.sv
rtl/core/prm_ctrl.sv
rtl/core/prm_dp.sv
rtl/core/pulse_interval_rate_meter.sv
dv/pulse_interval_rate_meter_tb.sv
